@@ rtl/core/gupc_pkg.sv @@
// Package for the grid path counter: sequencer step codes, jump conditions,
// control word layout and the microcode table. No dependencies.
package gupc_pkg;

   // Width of the rows and cols request fields.
   localparam int DIM_WIDTH = 7;

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_CHECK,
      STEP_CELL,
      STEP_DONE
   } step_type;

   typedef enum logic [2:0] {
      COND_REQ,
      COND_ZERO,
      COND_LAST,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     accept;   // request port open
      logic     walk;     // compute one cell
      logic     finish;   // load result register when cond holds
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } ctrl_word_type;

   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type cw;
      cw = '0;
      case (step)
         STEP_IDLE: begin
            cw.accept   = 1'b1;
            cw.cond     = COND_REQ;
            cw.on_true  = STEP_CHECK;
            cw.on_false = STEP_IDLE;
         end
         STEP_CHECK: begin
            cw.cond     = COND_ZERO;
            cw.on_true  = STEP_DONE;
            cw.on_false = STEP_CELL;
         end
         STEP_CELL: begin
            cw.walk     = 1'b1;
            cw.cond     = COND_LAST;
            cw.on_true  = STEP_DONE;
            cw.on_false = STEP_CELL;
         end
         STEP_DONE: begin
            cw.finish   = 1'b1;
            cw.cond     = COND_OUT_FREE;
            cw.on_true  = STEP_IDLE;
            cw.on_false = STEP_DONE;
         end
         default: begin
            cw.on_true  = STEP_IDLE;
            cw.on_false = STEP_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

@@ rtl/core/gupc_row_mem.sv @@
// One-row count store: one write port, one registered read port.
// Write-first on an address collision. No dependencies.
module gupc_row_mem #(
   parameter int  DEPTH = 64,
   parameter int  WIDTH = 31,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // single-column grids read back the cell written in the same cycle
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/grid_unique_path_counter.sv @@
// Grid path counter: monotone right/down paths across a rows x cols grid.
// Sequence: an accepted request passes the check step, a walk over the
//   rows x cols cells (clamped to MAX_ROWS x MAX_COLS; skipped when a
//   dimension is zero) and the done step, which loads the result register.
// One cell per cycle, by the single saturating adder and the one read / one
//   write port of the row store; a new request waits for the idle step.
// Reset: synchronous, active high; sequencer to idle, result register empty.
//   The row store is not cleared: the first row writes each entry before use.
module grid_unique_path_counter
   import gupc_pkg::*;
#(
   parameter int MAX_COLS    = 64,
   parameter int MAX_ROWS    = 64,
   parameter int COUNT_WIDTH = 31
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [DIM_WIDTH-1:0]   req_rows,
   input  logic [DIM_WIDTH-1:0]   req_cols,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COUNT_WIDTH-1:0] rsp_path_count,
   output logic                   rsp_overflowed
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   // ---------------------------------------------------------------
   // Sequencer: step counter plus microcode table in the package
   // ---------------------------------------------------------------
   step_type      step_ff, step_in;
   ctrl_word_type cw;
   logic          cond_met;

   // walk state
   logic [COL_W-1:0]       cols_last_ff, cols_last_in;
   logic [ROW_W-1:0]       rows_last_ff, rows_last_in;
   logic                   zero_ff, zero_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic                   sat_ff, sat_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   // datapath
   logic                   take_req;
   logic                   row_end, last_cell, corner;
   logic [COUNT_WIDTH-1:0] up_val, left_val, cell_val, rd_data;
   logic [COUNT_WIDTH:0]   sum_ext;
   logic                   carry;
   logic [COL_W-1:0]       rd_addr;
   logic                   out_free, load_out;

   assign cw       = microcode(step_ff);
   assign take_req = cw.accept && req_valid;
   assign row_end  = (col_ff == cols_last_ff);
   assign last_cell = row_end && (row_ff == rows_last_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_out = cw.finish && out_free;

   always_comb begin
      case (cw.cond)
         COND_REQ:      cond_met = req_valid;
         COND_ZERO:     cond_met = zero_ff;
         COND_LAST:     cond_met = last_cell;
         COND_OUT_FREE: cond_met = out_free;
         default:       cond_met = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      step_in = cond_met ? cw.on_true : cw.on_false;
   end

   // outputs of the control word
   always_comb begin
      req_ready = cw.accept;
   end

   // ---------------------------------------------------------------
   // Cell arithmetic: up + left, saturated; the corner cell is 1
   // ---------------------------------------------------------------
   assign corner   = (row_ff == '0) && (col_ff == '0);
   assign up_val   = (row_ff != '0) ? rd_data : '0;
   assign left_val = (col_ff != '0) ? left_ff : '0;
   assign sum_ext  = {1'b0, up_val} + {1'b0, left_val};
   assign carry    = sum_ext[COUNT_WIDTH];

   always_comb begin
      if (corner) begin
         cell_val = COUNT_ONE;
      end else if (carry) begin
         cell_val = COUNT_MAX;
      end else begin
         cell_val = sum_ext[COUNT_WIDTH-1:0];
      end
   end

   // prefetch the cell above the next one
   always_comb begin
      if (cw.walk && !row_end) begin
         rd_addr = col_ff + COL_W'(1);
      end else begin
         rd_addr = '0;
      end
   end

   gupc_row_mem #(
      .DEPTH (MAX_COLS),
      .WIDTH (COUNT_WIDTH)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (cw.walk),
      .wr_addr (col_ff),
      .wr_data (cell_val),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------
   // Walk registers
   // ---------------------------------------------------------------
   always_comb begin
      cols_last_in = cols_last_ff;
      rows_last_in = rows_last_ff;
      zero_in      = zero_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      left_in      = left_ff;
      sat_in       = sat_ff;
      if (take_req) begin
         // clamp to MAX_COLS and MAX_ROWS; zero dimensions skip the walk
         if (32'(req_cols) > MAX_COLS) begin
            cols_last_in = COL_W'(MAX_COLS - 1);
         end else begin
            cols_last_in = COL_W'(32'(req_cols) - 32'd1);
         end
         if (32'(req_rows) > MAX_ROWS) begin
            rows_last_in = ROW_W'(MAX_ROWS - 1);
         end else begin
            rows_last_in = ROW_W'(32'(req_rows) - 32'd1);
         end
         zero_in = (req_rows == '0) || (req_cols == '0);
         col_in  = '0;
         row_in  = '0;
         sat_in  = 1'b0;
      end else if (cw.walk) begin
         left_in = cell_val;
         sat_in  = sat_ff || (carry && !corner);
         if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cols_last_ff <= cols_last_in;
      rows_last_ff <= rows_last_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      left_ff      <= left_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         zero_ff <= 1'b0;
         sat_ff  <= 1'b0;
      end else begin
         step_ff <= step_in;
         zero_ff <= zero_in;
         sat_ff  <= sat_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register: frees the sequencer while a result waits
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = zero_ff ? '0 : left_ff;
         rsp_ovf_in   = sat_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;
   assign rsp_overflowed = rsp_ovf_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CELL) |-> (col_ff <= cols_last_ff))
      else $error("column index past the requested width");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (step_ff == STEP_CHECK))
      else $error("accepted request did not start the sequence");

   a_zero_no_sat: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_DONE && zero_ff) |-> !sat_ff)
      else $error("zero-dimension request flagged overflow");

   a_ovf_saturated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflowed) |-> (rsp_path_count == COUNT_MAX))
      else $error("overflow reported without a saturated count");

endmodule
